### src/sha_pkg.sv
// SHA-256 hasher package: round constants, initial hash values and shared types.
// Used by sha_core and the sha256_byte_stream_hasher top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
  } core_ctrl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

### src/sha_core.sv
// SHA-256 compression unit: one round per cycle over a 16-word schedule window.
// Depends on sha_pkg. Block words arrive through blk; chaining words are kept by the caller.
`timescale 1ns / 1ps
`default_nettype none
module sha_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha_pkg::core_ctrl_t ctrl_in,
  input  wire logic [511:0]       blk,
  input  wire logic [255:0]       h_in,
  output logic                    done,
  output logic [255:0]            h_out
);
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  round;
  logic        run;
  logic [31:0] t1, t2, s0, s1, w_new, e, a;

  assign e = v[4];
  assign a = v[0];
  assign t1 = v[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
            + ((e & v[5]) ^ (~e & v[6])) + sha_pkg::round_k(round) + w[0];
  assign t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
            + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  assign s0 = sha_pkg::ror(w[1], 7) ^ sha_pkg::ror(w[1], 18) ^ (w[1] >> 3);
  assign s1 = sha_pkg::ror(w[14], 17) ^ sha_pkg::ror(w[14], 19) ^ (w[14] >> 10);
  assign w_new = s1 + w[9] + s0 + w[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      round <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl_in.start && !run) begin
        run   <= 1'b1;
        round <= '0;
      end else if (run) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.start && !run) begin
      for (int i = 0; i < 16; i++) w[i] <= blk[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++)  v[i] <= h_in[255 - 32*i -: 32];
    end else if (run) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) h_out[255 - 32*i -: 32] = v[i];
  end
endmodule
`default_nettype wire

### src/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher, top level: byte intake, padding sequencer, digest output.
// Depends on sha_pkg and sha_core.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   s_axis: one item per transfer. tuser = cmd (0 absorb, 1 finish),
//   tdata[7:0] = message byte. m_axis: eight digest words after a finish,
//   tdata = {word_index, digest_word} padded, tlast on word 7.
// Intake: an absorbed byte leaves s_axis_tready high unless it fills the block;
//   then s_axis_tready stays low through the load state, the round state
//   (the rounds, then the done flag) and the fold state. The round unit
//   sets the length of the round state.
// A finish shifts the padding into the block buffer one byte per cycle
//   (no padding bytes when the marker fills the block), runs one compression,
//   and for offsets 56 and above pads a second block and compresses again.
//   It then offers eight words, one per cycle while the receiver takes them;
//   a stall holds the current word and keeps s_axis_tready low.
// Reset (rst, synchronous) restores the initial hash values and clears the
//   byte count; the block buffer is not cleared, every byte is written
//   before it is used.
module sha256_byte_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // message_byte
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic             m_axis_tlast    // last_word
);
  sha_pkg::state_t state, state_next;
  logic [60:0]  count;
  logic [5:0]   pos;
  logic         finishing, second;
  logic [63:0]  bits;
  logic [255:0] h, h_core;
  logic [511:0] blk;
  logic         core_done;
  logic [2:0]   widx;
  sha_pkg::core_ctrl_t ctrl;
  logic         acc;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == sha_pkg::ST_IDLE);
  assign ctrl.start = (state == sha_pkg::ST_LOAD);

  sha_core u_core (
    .clk(clk), .rst(rst), .ctrl_in(ctrl), .blk(blk), .h_in(h),
    .done(core_done), .h_out(h_core)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= sha_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::ST_IDLE:
        if (acc) begin
          if (s_axis_tuser) begin
            if (pos == 6'd63) state_next = sha_pkg::ST_LOAD;
            else state_next = sha_pkg::ST_PAD;
          end else if (pos == 6'd63) state_next = sha_pkg::ST_LOAD;
        end
      sha_pkg::ST_PAD:
        if (pos == 6'd63) state_next = sha_pkg::ST_LOAD;
      sha_pkg::ST_LOAD:  state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (core_done) state_next = sha_pkg::ST_FOLD;
      sha_pkg::ST_FOLD:
        if (!finishing) state_next = sha_pkg::ST_IDLE;
        else if (second) state_next = sha_pkg::ST_PAD;
        else state_next = sha_pkg::ST_EMIT;
      sha_pkg::ST_EMIT:
        if (m_axis_tready && widx == 3'd7) state_next = sha_pkg::ST_IDLE;
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // Bytes shift in at the low end; after 64 shifts the first byte sits at the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; pos <= '0; finishing <= 1'b0; second <= 1'b0; widx <= '0;
      for (int i = 0; i < 8; i++) h[255 - 32*i -: 32] <= sha_pkg::init_h(3'(i));
    end else begin
      unique case (state)
        sha_pkg::ST_IDLE:
          if (acc) begin
            if (s_axis_tuser) begin
              blk       <= {blk[503:0], 8'h80};
              bits      <= {count, 3'b000};
              finishing <= 1'b1;
              second    <= (pos > 6'd55);
              pos       <= pos + 6'd1;
              // 0x80 landed at offset 63: block is full, compress it as is
              if (pos == 6'd63) pos <= 6'd63;
            end else begin
              blk   <= {blk[503:0], s_axis_tdata};
              count <= count + 61'd1;
              if (pos != 6'd63) pos <= pos + 6'd1;
            end
          end
        sha_pkg::ST_PAD: begin
          // zero fill; length bytes go into offsets 56..63 of the final block
          if (!second && pos >= 6'd56) blk <= {blk[503:0], bits[63 - 8*(pos - 6'd56) -: 8]};
          else blk <= {blk[503:0], 8'h00};
          if (pos != 6'd63) pos <= pos + 6'd1;
        end
        sha_pkg::ST_FOLD: begin
          for (int i = 0; i < 8; i++)
            h[255 - 32*i -: 32] <= h[255 - 32*i -: 32] + h_core[255 - 32*i -: 32];
          pos <= '0;
          if (second) second <= 1'b0;
          widx <= '0;
        end
        sha_pkg::ST_EMIT:
          if (m_axis_tready) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              finishing <= 1'b0;
              count <= '0;
              for (int i = 0; i < 8; i++) h[255 - 32*i -: 32] <= sha_pkg::init_h(3'(i));
            end
          end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = (state == sha_pkg::ST_EMIT);
  assign m_axis_tdata  = {5'b0, widx, h[255 - 32*widx -: 32]};
  assign m_axis_tlast  = (widx == 3'd7);
endmodule
`default_nettype wire

### src/sha_checker.sv
// Port-level checker for sha256_byte_stream_hasher, bound to the top level.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during digest output");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast not on word 7");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1)
    else $error("word index skipped");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled word changed");
endmodule
bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
`default_nettype wire
